@@ rtl/core/gcsa_pkg.sv @@
// Shared types, codes and command/status bundles for the glyph cache shelf allocator.
package gcsa_pkg;

  // Result status codes
  localparam logic [1:0] StatusHit    = 2'd0;
  localparam logic [1:0] StatusPlaced = 2'd1;
  localparam logic [1:0] StatusEmpty  = 2'd2;
  localparam logic [1:0] StatusNoRoom = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] RegAtlasWidth  = 8'd0;
  localparam logic [7:0] RegAtlasHeight = 8'd1;

  // Reset value of both atlas side registers
  localparam logic [12:0] AtlasSideReset = 13'd4096;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT,
    S_PLACE,
    S_OUT
  } gcsa_state_e;

  // One cache slot
  typedef struct packed {
    logic [15:0] glyph;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // capture request, restart scan
    logic scan;      // issue next slot read
    logic hit_load;  // take result from slot read data
    logic evict;     // drop oldest if full, wrap row if needed
    logic place;     // insert entry or report no room
    logic out_load;  // move result into the output register
  } gcsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } gcsa_sts_t;

endpackage

@@ rtl/core/gcsa_ctrl.sv @@
// Controller state machine of the glyph cache shelf allocator.
module gcsa_ctrl
  import gcsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gcsa_sts_t sts_i,
  output gcsa_cmd_t cmd_o
);

  gcsa_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit) state_d = S_OUT;
        else if (sts_i.scan_done) state_d = S_EVICT;
      end
      S_EVICT: state_d = S_PLACE;
      S_PLACE: state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan     = 1'b1;
        cmd_o.hit_load = sts_i.hit;
      end
      S_EVICT: cmd_o.evict = 1'b1;
      S_PLACE: cmd_o.place = 1'b1;
      S_OUT:   cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/core/gcsa_dp.sv @@
// Datapath: slot memory, scan counter, packing cursor, config and output registers.
module gcsa_dp
  import gcsa_pkg::*;
#(
  parameter int CACHE_ENTRIES  = 256,
  parameter int MAX_ATLAS_SIDE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic [47:0] in_data_i,
  input  gcsa_cmd_t   cmd_i,
  output gcsa_sts_t   sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [55:0] out_data_o,
  output logic [1:0]  out_user_o
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W:0] NumEnt = (CNT_W + 1)'(CACHE_ENTRIES);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(CACHE_ENTRIES);
  localparam logic [CNT_W-1:0] FullCntM1 = CNT_W'(CACHE_ENTRIES - 1);
  localparam logic [14:0] MaxSide = 15'(MAX_ATLAS_SIDE);

  // Slot memory
  slot_t mem [CACHE_ENTRIES];
  slot_t rd_q;
  logic  rd_pend_q, rd_pend_d;

  // Config registers
  logic [12:0] atlas_w_q, atlas_h_q;

  // Request and queue state
  logic [15:0]      req_glyph_q;
  logic [12:0]      req_w_q, req_h_q;
  logic [CNT_W-1:0] k_q;
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0] filled_q, filled_d;

  // Packing cursor
  logic [12:0] cx_q, cx_d;
  logic [13:0] cy_q, cy_d;
  logic [12:0] rh_q, rh_d;

  // Result and output registers
  logic [1:0]  res_st_q;
  logic [11:0] res_x_q, res_y_q;
  logic [12:0] res_w_q, res_h_q;
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic [1:0]  out_user_q;

  // Combinational helpers
  logic [CNT_W:0]   rd_sum, rd_wrap, ins_sum, ins_wrap;
  logic [IDX_W-1:0] rd_addr, ins_addr;
  logic             issue;
  logic [14:0]      aw, ah, wrap_sum, fit_sum, cy_sum;
  logic             empty_g, no_room;
  logic             mem_we;
  slot_t            wr_slot;

  // Update config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= AtlasSideReset;
      atlas_h_q <= AtlasSideReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAtlasWidth:  atlas_w_q <= cfg_data_i;
        RegAtlasHeight: atlas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp atlas sides
  always_comb begin
    aw = {2'b00, atlas_w_q};
    ah = {2'b00, atlas_h_q};
    if (aw > MaxSide) aw = MaxSide;
    if (ah > MaxSide) ah = MaxSide;
  end

  // Scan address, oldest plus k modulo the depth
  always_comb begin
    rd_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(k_q);
    rd_wrap = (rd_sum >= NumEnt) ? rd_sum - NumEnt : rd_sum;
    rd_addr = rd_wrap[IDX_W-1:0];
    issue   = cmd_i.scan && (k_q != filled_q);
    rd_pend_d = issue;
  end

  // Insert address, oldest plus fill count modulo the depth
  always_comb begin
    ins_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(filled_q);
    ins_wrap = (ins_sum >= NumEnt) ? ins_sum - NumEnt : ins_sum;
    ins_addr = ins_wrap[IDX_W-1:0];
  end

  assign empty_g  = (req_w_q == 13'd0) || (req_h_q == 13'd0);
  assign wrap_sum = {2'b00, cx_q} + {2'b00, req_w_q};
  assign cy_sum   = {1'b0, cy_q} + {2'b00, rh_q};
  assign fit_sum  = {1'b0, cy_q} + {2'b00, req_h_q};
  assign no_room  = ({2'b00, req_w_q} > aw) || (fit_sum > ah);

  // Evict, wrap and place
  always_comb begin
    oldest_d = oldest_q;
    filled_d = filled_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rh_d     = rh_q;
    mem_we   = 1'b0;
    wr_slot  = '0;
    wr_slot.glyph = req_glyph_q;
    if (cmd_i.evict) begin
      if (filled_q >= FullCnt) begin
        oldest_d = (oldest_q == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : oldest_q + 1'b1;
        filled_d = FullCntM1;
      end
      if (!empty_g && (wrap_sum > aw)) begin
        cx_d = '0;
        cy_d = cy_sum[14] ? '1 : cy_sum[13:0];
        rh_d = '0;
      end
    end
    if (cmd_i.place) begin
      if (empty_g) begin
        mem_we = 1'b1;
      end else if (!no_room) begin
        mem_we    = 1'b1;
        wr_slot.x = cx_q[11:0];
        wr_slot.y = cy_q[11:0];
        wr_slot.w = req_w_q;
        wr_slot.h = req_h_q;
        cx_d      = cx_q + req_w_q;
        if (req_h_q > rh_q) rh_d = req_h_q;
      end
      if (mem_we && (filled_q < FullCnt)) filled_d = filled_q + 1'b1;
    end
  end

  // Write and read the slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ins_addr] <= wr_slot;
    if (issue) rd_q <= mem[rd_addr];
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      filled_q  <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      rh_q      <= '0;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      filled_q <= filled_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      rh_q     <= rh_d;
      if (cmd_i.start) begin
        k_q       <= '0;
        rd_pend_q <= 1'b0;
      end else begin
        if (issue) k_q <= k_q + 1'b1;
        rd_pend_q <= rd_pend_d;
      end
    end
  end

  // Capture request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_glyph_q <= in_data_i[15:0];
      req_w_q     <= in_data_i[28:16];
      req_h_q     <= in_data_i[41:29];
    end
  end

  // Latch the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_load) begin
      res_st_q <= StatusHit;
      res_x_q  <= rd_q.x;
      res_y_q  <= rd_q.y;
      res_w_q  <= rd_q.w;
      res_h_q  <= rd_q.h;
    end else if (cmd_i.place) begin
      res_st_q <= empty_g ? StatusEmpty : (no_room ? StatusNoRoom : StatusPlaced);
      res_x_q  <= (empty_g || no_room) ? 12'd0 : cx_q[11:0];
      res_y_q  <= (empty_g || no_room) ? 12'd0 : cy_q[11:0];
      res_w_q  <= (empty_g || no_room) ? 13'd0 : req_w_q;
      res_h_q  <= (empty_g || no_room) ? 13'd0 : req_h_q;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {6'd0, res_h_q, res_w_q, res_y_q, res_x_q};
      out_user_q <= res_st_q;
    end
  end

  assign sts_o.hit       = rd_pend_q && (rd_q.glyph == req_glyph_q);
  assign sts_o.scan_done = !rd_pend_q && (k_q == filled_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

@@ rtl/core/glyph_cache_shelf_allocator.sv @@
// Top level of the glyph cache shelf allocator: controller plus datapath.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata: glyph_id, box_width, box_height
//  m_axis    out        tvalid/tready           tdata: placement, tuser: status
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A request scans the filled slots from the oldest on until a hit; on a miss, also with the
// table empty, it goes on to evict and place. The scan reads the slot memory through
// its one read port, one slot a cycle, and a miss is seen once the last read has come back.
// Reset clears the cursor and fill count at once; slot contents are not cleared.
// A stalled output holds its word; the next request is taken while it waits,
// and its result is loaded once the output register frees up.
module glyph_cache_shelf_allocator
  import gcsa_pkg::*;
#(
  parameter int CACHE_ENTRIES  = 256,
  parameter int MAX_ATLAS_SIDE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // glyph_id[15:0], box_width[28:16], box_height[41:29]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // place_x[11:0], place_y[23:12], place_width[36:24], place_height[49:37]
  output logic [55:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  gcsa_cmd_t cmd;
  gcsa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gcsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gcsa_dp #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .MAX_ATLAS_SIDE (MAX_ATLAS_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

@@ rtl/core/gcsa_chk.sv @@
// Port-level checker for the glyph cache shelf allocator, with its bind.
module gcsa_chk
  import gcsa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // Empty and no-room results carry an all-zero box
  a_zero_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == StatusEmpty || m_axis_tuser_o == StatusNoRoom)
      |-> m_axis_tdata_o[49:0] == 50'd0)
    else $error("empty or no-room result with nonzero box");

  // A new placement has a nonzero box
  a_placed_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == StatusPlaced)
      |-> (m_axis_tdata_o[36:24] != 13'd0) && (m_axis_tdata_o[49:37] != 13'd0))
    else $error("placed result with empty box");

  // One request at a time: drop ready after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

endmodule

bind glyph_cache_shelf_allocator gcsa_chk u_gcsa_chk (.*);
